### hdl/heq_pkg.sv
// Shared constants, command codes and divider interface types for the histogram equalizer.
`timescale 1ns / 1ps

package heq_pkg;

    // Histogram geometry
    localparam int COUNT_BITS = 21;
    localparam int PC_BITS    = 21;
    localparam int ADDR_BITS  = 8;
    localparam int LEVELS     = 1 << ADDR_BITS;
    localparam int QUOT_BITS  = 8;

    // Running sum of all bins and 255 * running sum
    localparam int CDF_BITS = COUNT_BITS + ADDR_BITS;
    localparam int NUM_BITS = CDF_BITS + QUOT_BITS;

    localparam logic [PC_BITS-1:0]    PC_RESET = PC_BITS'(65536);
    localparam logic [QUOT_BITS-1:0]  GREY_MAX = {QUOT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] BIN_MAX  = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_BUILD = 2'd2,
        CMD_MAP   = 2'd3
    } t_cmd;

    // Divider request: start pulse, dividend and divisor
    typedef struct packed {
        logic                start;
        logic [NUM_BITS-1:0] num;
        logic [PC_BITS-1:0]  den;
    } t_div_req;

    // Divider response: one-cycle done pulse and clamped quotient
    typedef struct packed {
        logic                 done;
        logic [QUOT_BITS-1:0] quot;
    } t_div_rsp;

endpackage

### hdl/histogram_equalizer_core.sv
// Top level of the 8-bit histogram equalizer: bin memory, level map and build sequencer.
`timescale 1ns / 1ps

// Clear, count and map commands are taken one per cycle while busy is low. A map
// command returns its equalized value on o_out_pixel with o_strobe high in the
// cycle right after it was accepted; the receiver cannot stall, so a result is
// seen exactly once. Counts are read-modify-write on the bin memory with a
// forward of the previous cycle's write, so repeated pixels back to back are
// counted correctly; a clear resets all per-bin valid flags together. A build
// raises busy and walks the 256 bins one at a time: each bin costs one memory
// read, one accumulate, one scale step and the serial divider (one quotient bit
// per cycle), whose iteration is skipped when the entry clamps to 255. The user
// must write pixel_count only while idle; the block itself does not enforce it.
module histogram_equalizer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_cmd,
    input  logic [7:0]                   i_pixel,
    output logic                         o_strobe,
    output logic [7:0]                   o_out_pixel,
    input  logic                         i_cfg_we,
    input  logic [heq_pkg::PC_BITS-1:0]  i_cfg_wdata
);

    localparam int AB = heq_pkg::ADDR_BITS;
    localparam int CB = heq_pkg::COUNT_BITS;
    localparam int DB = heq_pkg::CDF_BITS;
    localparam int QB = heq_pkg::QUOT_BITS;
    localparam int NL = heq_pkg::LEVELS;

    typedef enum logic [1:0] {
        S_RUN,
        S_RD,
        S_ACC,
        S_DIV
    } t_state;

    // Build state and stage bookkeeping
    t_state  r_state;
    logic    r_num_go;
    logic [AB-1:0] r_bin;
    logic [DB-1:0] r_cdf;
    logic          r_s2_cnt;
    logic [AB-1:0] r_s2_addr;
    logic          r_fwd_v;
    logic [AB-1:0] r_fwd_addr;
    logic [CB-1:0] r_fwd_data;
    logic          r_strobe;
    logic [heq_pkg::PC_BITS-1:0] r_pixel_count;

    // Memories
    logic [CB-1:0] bin_mem [NL];
    logic [QB-1:0] map_mem [NL];
    logic [NL-1:0] r_bin_valid;
    logic [CB-1:0] r_rd_data;
    logic          r_rd_valid;
    logic [QB-1:0] r_map_rd;

    logic          accept;
    heq_pkg::t_cmd cmd;
    logic [AB-1:0] rd_addr;
    logic [CB-1:0] old_cnt;
    logic [CB-1:0] n_cnt;
    logic [CB-1:0] rd_bin;
    logic          map_we;

    heq_pkg::t_div_req div_req;
    heq_pkg::t_div_rsp div_rsp;

    assign busy   = (r_state != S_RUN);
    assign accept = start && !busy;
    assign cmd    = heq_pkg::t_cmd'(i_cmd);

    // Bin memory address: incoming pixel while running, bin walker in a build
    assign rd_addr = (r_state == S_RUN) ? i_pixel : r_bin;

    // Count update with forward from the write of the previous cycle
    assign rd_bin  = r_rd_valid ? r_rd_data : '0;
    assign old_cnt = (r_fwd_v && (r_fwd_addr == r_s2_addr)) ? r_fwd_data : rd_bin;
    assign n_cnt   = (old_cnt == heq_pkg::BIN_MAX) ? old_cnt : old_cnt + CB'(1);

    assign map_we = (r_state == S_DIV) && div_rsp.done;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= heq_pkg::PC_RESET;
        end else if (i_cfg_we) begin
            r_pixel_count <= i_cfg_wdata;
        end
    end

    // Bin valid flags: clear wins over a count finishing in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_valid <= '0;
        end else if (accept && cmd == heq_pkg::CMD_CLEAR) begin
            r_bin_valid <= '0;
        end else if (r_s2_cnt) begin
            r_bin_valid[r_s2_addr] <= 1'b1;
        end
    end

    // Bin count memory, one read and one write port
    always_ff @(posedge i_clk) begin
        if (r_s2_cnt) begin
            bin_mem[r_s2_addr] <= n_cnt;
        end
        r_rd_data  <= bin_mem[rd_addr];
        r_rd_valid <= r_bin_valid[rd_addr];
    end

    // Level map memory
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[r_bin] <= div_rsp.quot;
        end
        r_map_rd <= map_mem[i_pixel];
    end

    // Scale the running sum by 255 and hand it to the divider
    assign div_req.start = r_num_go;
    assign div_req.num   = {r_cdf, {QB{1'b0}}} - heq_pkg::NUM_BITS'(r_cdf);
    assign div_req.den   = r_pixel_count;

    heq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Command pipeline and build sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RUN;
            r_num_go <= 1'b0;
            r_s2_cnt <= 1'b0;
            r_fwd_v  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_num_go   <= 1'b0;
            r_s2_cnt   <= accept && cmd == heq_pkg::CMD_COUNT;
            r_s2_addr  <= i_pixel;
            r_fwd_v    <= r_s2_cnt;
            r_fwd_addr <= r_s2_addr;
            r_fwd_data <= n_cnt;
            r_strobe   <= accept && cmd == heq_pkg::CMD_MAP;
            case (r_state)
                S_RUN: begin
                    if (accept && cmd == heq_pkg::CMD_BUILD) begin
                        r_bin   <= '0;
                        r_cdf   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_cdf    <= r_cdf + DB'(rd_bin);
                    r_num_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (r_bin == AB'(NL - 1)) begin
                            r_state <= S_RUN;
                        end else begin
                            r_bin   <= r_bin + AB'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    assign o_strobe    = r_strobe;
    assign o_out_pixel = r_map_rd;

`ifndef ASSERT_OFF
    // A result appears only for a map command taken the cycle before
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && i_cmd == heq_pkg::CMD_MAP))
        else $error("result strobe without a map transaction");

    // No count can still be in flight once a build has started
    a_build_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> !r_s2_cnt)
        else $error("count write pending during build");

    // Divider answers only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    // Each bin walk step restarts the divider exactly once
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_num_go |-> $past(r_state == S_ACC))
        else $error("divider started out of sequence");
`endif

endmodule

### hdl/heq_div.sv
// Bit-serial restoring divider giving an 8-bit quotient clamped to 255.
`timescale 1ns / 1ps

module heq_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  heq_pkg::t_div_req i_req,
    output heq_pkg::t_div_rsp o_rsp
);

    localparam int NB = heq_pkg::NUM_BITS;
    localparam int QB = heq_pkg::QUOT_BITS;

    logic          r_busy;
    logic          r_done;
    logic [2:0]    r_step;
    logic [NB-1:0] r_rem;
    logic [NB-1:0] r_dsh;
    logic [QB-1:0] r_quot;

    logic          ovf;
    logic          ge;
    logic [NB-1:0] n_rem;

    // Quotient would exceed 8 bits: clamp without iterating
    assign ovf   = i_req.num >= NB'({i_req.den, {QB{1'b0}}});
    assign ge    = r_rem >= r_dsh;
    assign n_rem = ge ? (r_rem - r_dsh) : r_rem;

    // One quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (ovf) begin
                    r_quot <= heq_pkg::GREY_MAX;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_req.num;
                    r_dsh  <= NB'({i_req.den, {(QB-1){1'b0}}});
                    r_quot <= '0;
                    r_step <= 3'(QB - 1);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_dsh  <= r_dsh >> 1;
                r_quot <= {r_quot[QB-2:0], ge};
                if (r_step == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 3'd1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

### tb/tb.sv
// Self-checking testbench for the histogram equalizer core: directed table, then random phases.
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS = 600;
    // Longest quiet stretch: one build plus sender gaps and config waits
    localparam int IDLE_LIMIT   = 20000;

    // One row of the directed table: a pixel_count write or a command
    typedef struct packed {
        logic                          is_cfg;
        logic [heq_pkg::PC_BITS-1:0]   cfg_val;
        heq_pkg::t_cmd                 cmd;
        logic [7:0]                    pixel;
        logic                          typed;
        logic [heq_pkg::QUOT_BITS-1:0] typed_level;
    } t_plan_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [1:0]                  i_cmd;
    logic [7:0]                  i_pixel;
    logic                        o_strobe;
    logic [7:0]                  o_out_pixel;
    logic                        i_cfg_we;
    logic [heq_pkg::PC_BITS-1:0] i_cfg_wdata;

    // Shadow state of the block
    logic [heq_pkg::COUNT_BITS-1:0] bin_tally [heq_pkg::LEVELS];
    logic [heq_pkg::QUOT_BITS-1:0]  level_lut [heq_pkg::LEVELS];
    logic [heq_pkg::PC_BITS-1:0]    img_pixels;
    bit                             lut_valid;

    // Levels still owed by the block, oldest first
    logic [heq_pkg::QUOT_BITS-1:0] exp_levels [$];
    logic [heq_pkg::QUOT_BITS-1:0] want_level;

    t_plan_row plan [$];

    int errors;
    int n_items;
    int n_levels;
    int n_builds;
    int n_cfg;
    int burst_left;
    int idle_cycles;

    histogram_equalizer_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_pixel     (i_pixel),
        .o_strobe    (o_strobe),
        .o_out_pixel (o_out_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    function automatic t_plan_row item_row(heq_pkg::t_cmd c, logic [7:0] px, logic typed,
                                           logic [heq_pkg::QUOT_BITS-1:0] lvl);
        t_plan_row r;
        r = '0;
        r.cmd = c;
        r.pixel = px;
        r.typed = typed;
        r.typed_level = lvl;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(logic [heq_pkg::PC_BITS-1:0] val);
        t_plan_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cfg_val = val;
        r.cmd = heq_pkg::CMD_CLEAR;
        return r;
    endfunction

    // Send one command, wait for the handshake, then update the shadow state
    task automatic issue(heq_pkg::t_cmd c, logic [7:0] px, logic typed,
                         logic [heq_pkg::QUOT_BITS-1:0] lvl);
        logic [63:0] running;
        logic [63:0] q;
        int          v;
        int          gap;
        start   <= 1'b1;
        i_cmd   <= c;
        i_pixel <= px;
        do @(posedge i_clk); while (busy);
        n_items++;
        case (c)
            heq_pkg::CMD_CLEAR: begin
                for (v = 0; v < heq_pkg::LEVELS; v++) bin_tally[v] = '0;
            end
            heq_pkg::CMD_COUNT: begin
                if (bin_tally[px] != heq_pkg::BIN_MAX) bin_tally[px] = bin_tally[px] + 1'b1;
            end
            heq_pkg::CMD_BUILD: begin
                // level = floor(255 * cdf / pixel_count), clamped; all 255 on zero count
                running = '0;
                for (v = 0; v < heq_pkg::LEVELS; v++) begin
                    running = running + bin_tally[v];
                    if (img_pixels == '0) begin
                        q = heq_pkg::GREY_MAX;
                    end else begin
                        q = (64'd255 * running) / img_pixels;
                        if (q > heq_pkg::GREY_MAX) q = heq_pkg::GREY_MAX;
                    end
                    level_lut[v] = q[heq_pkg::QUOT_BITS-1:0];
                end
                lut_valid = 1'b1;
                n_builds++;
            end
            heq_pkg::CMD_MAP: begin
                exp_levels.push_back(typed ? lvl : level_lut[px]);
            end
            default: begin
            end
        endcase
        // Sender bursts: short or long runs, random gaps in between
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end else begin
            burst_left--;
        end
    endtask

    // Hold off until every owed level has come and the block is idle
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (exp_levels.size() != 0);
        // a build yields no result, so give busy time to show up
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_pixel_count(logic [heq_pkg::PC_BITS-1:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        img_pixels = val;
        n_cfg++;
    endtask

    // Result checker: the receiver cannot stall, every strobe is one transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            n_levels++;
            if (exp_levels.size() == 0) begin
                $display("%0t: unexpected level, expected none, actual %0d",
                         $time, o_out_pixel);
                errors++;
            end else begin
                want_level = exp_levels.pop_front();
                if (o_out_pixel !== want_level) begin
                    $display("%0t: out_pixel mismatch, expected %0d, actual %0d",
                             $time, want_level, o_out_pixel);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int                          i;
        int                          n_cnt;
        int                          n_directed;
        int                          hist_total;
        int                          target;
        bit                          fresh;
        heq_pkg::t_cmd               c;
        logic [7:0]                  base;
        logic [7:0]                  px;
        logic [heq_pkg::PC_BITS-1:0] pc;

        start       = 1'b0;
        i_cmd       = heq_pkg::CMD_CLEAR;
        i_pixel     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        errors      = 0;
        n_items     = 0;
        n_levels    = 0;
        n_builds    = 0;
        n_cfg       = 0;
        burst_left  = 0;
        idle_cycles = 0;
        lut_valid   = 1'b0;
        img_pixels  = heq_pkg::PC_RESET;
        for (i = 0; i < heq_pkg::LEVELS; i++) begin
            bin_tally[i] = '0;
            level_lut[i] = '0;
        end

        // Directed table; typed levels only where obvious
        // empty histogram at reset count maps everything to 0
        plan.push_back(item_row(heq_pkg::CMD_BUILD, 8'd0,   1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_MAP,   8'd0,   1'b1, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_MAP,   8'd255, 1'b1, 8'd0));
        // extreme bins, repeated pixel, back to back unless a sender gap falls between
        plan.push_back(item_row(heq_pkg::CMD_COUNT, 8'd0,   1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_COUNT, 8'd255, 1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_COUNT, 8'd255, 1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_COUNT, 8'd255, 1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_BUILD, 8'd0,   1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_MAP,   8'd0,   1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_MAP,   8'd254, 1'b0, 8'd0));
        // cdf above pixel_count clamps
        plan.push_back(cfg_row(heq_pkg::PC_BITS'(1)));
        plan.push_back(item_row(heq_pkg::CMD_BUILD, 8'd0,   1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_MAP,   8'd0,   1'b1, heq_pkg::GREY_MAX));
        plan.push_back(item_row(heq_pkg::CMD_MAP,   8'd200, 1'b1, heq_pkg::GREY_MAX));
        // zero pixel_count gives all 255
        plan.push_back(cfg_row(heq_pkg::PC_BITS'(0)));
        plan.push_back(item_row(heq_pkg::CMD_CLEAR, 8'd0,   1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_BUILD, 8'd0,   1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_MAP,   8'd77,  1'b1, heq_pkg::GREY_MAX));
        // tiny image of three pixels: levels 0, 85, 255
        plan.push_back(cfg_row(heq_pkg::PC_BITS'(3)));
        plan.push_back(item_row(heq_pkg::CMD_COUNT, 8'd1,   1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_COUNT, 8'd2,   1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_COUNT, 8'd2,   1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_BUILD, 8'd0,   1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_MAP,   8'd0,   1'b1, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_MAP,   8'd1,   1'b1, 8'd85));
        plan.push_back(item_row(heq_pkg::CMD_MAP,   8'd2,   1'b1, heq_pkg::GREY_MAX));
        // largest divisor
        plan.push_back(cfg_row('1));
        plan.push_back(item_row(heq_pkg::CMD_BUILD, 8'd0,   1'b0, 8'd0));
        plan.push_back(item_row(heq_pkg::CMD_MAP,   8'd255, 1'b0, 8'd0));
        // bin saturation needs 2^21 counts of one pixel, beyond this run length

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                set_pixel_count(plan[k].cfg_val);
            end else begin
                issue(plan[k].cmd, plan[k].pixel, plan[k].typed, plan[k].typed_level);
            end
        end
        n_directed = n_items;
        target = n_directed + RANDOM_ITEMS;

        // Random phases: mostly clear, counts, build, maps; some noise in between
        while (n_items < target) begin
            n_cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 40);
            fresh = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0) begin
                hist_total = 0;
                if (!fresh) begin
                    for (i = 0; i < heq_pkg::LEVELS; i++) hist_total += bin_tally[i];
                end
                case ($urandom_range(0, 9))
                    0: pc = '0;
                    1: pc = heq_pkg::PC_BITS'(1);
                    2: pc = '1;
                    3: pc = heq_pkg::PC_BITS'(1 << 20);
                    4: pc = heq_pkg::PC_BITS'($urandom);
                    default: begin
                        // near the true image size so levels spread over the range
                        i = hist_total + n_cnt + $urandom_range(0, 6) - 3;
                        pc = (i < 0) ? '0 : heq_pkg::PC_BITS'(i);
                    end
                endcase
                set_pixel_count(pc);
            end else if ($urandom_range(0, 3) == 0) begin
                drain();
            end

            if (fresh) begin
                px = $urandom;
                issue(heq_pkg::CMD_CLEAR, px, 1'b0, 8'd0);
            end
            base = $urandom;
            repeat (n_cnt) begin
                px = ($urandom_range(0, 1) == 0) ? 8'(base + $urandom_range(0, 7))
                                                 : 8'($urandom);
                issue(heq_pkg::CMD_COUNT, px, 1'b0, 8'd0);
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    c = heq_pkg::t_cmd'($urandom_range(0, 3));
                    if (c == heq_pkg::CMD_MAP && !lut_valid) c = heq_pkg::CMD_COUNT;
                    px = $urandom;
                    issue(c, px, 1'b0, 8'd0);
                end
            end
            issue(heq_pkg::CMD_BUILD, base, 1'b0, 8'd0);
            repeat ($urandom_range(4, 40)) begin
                px = ($urandom_range(0, 1) == 0) ? 8'(base + $urandom_range(0, 7))
                                                 : 8'($urandom);
                issue(heq_pkg::CMD_MAP, px, 1'b0, 8'd0);
            end
        end

        // Wind down: all levels in, block idle, then a short tail
        start <= 1'b0;
        while (exp_levels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Sent %0d commands (%0d directed), %0d builds, %0d pixel_count writes.",
                 n_items, n_directed, n_builds, n_cfg);
        $display("Checked %0d equalized levels, %0d mismatches.", n_levels, errors);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
